### rtl/core/rgb_to_ycbcr_subsample_pack_assert.svh
// assertion macros shared by the rgb to ycbcr packer modules
// expects clk_i and rst_ni in the scope of each use
`ifndef RGB_TO_YCBCR_SUBSAMPLE_PACK_ASSERT_SVH
`define RGB_TO_YCBCR_SUBSAMPLE_PACK_ASSERT_SVH

// same-cycle implication
`define RYSP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RYSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rysp_pkg.sv
// shared types, codes and fixed-point constants of the rgb to ycbcr packer
// no dependencies
package rysp_pkg;

  localparam int COEF_FRAC_BITS = 16;
  // sums stay below 2^(frac+9), plus a sign bit
  localparam int SUM_W = COEF_FRAC_BITS + 10;

  localparam int DIM_W = 13;
  localparam int CNT_W = 12;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_OUTPUT_FORMAT = 3'd2;
  localparam logic [2:0] REG_CHROMA_SCALE  = 3'd3;
  localparam logic [2:0] REG_UV_SWAP       = 3'd4;

  // output formats
  localparam logic [1:0] FMT_PLANAR = 2'd0;
  localparam logic [1:0] FMT_YUYV   = 2'd1;
  localparam logic [1:0] FMT_UYVY   = 2'd2;

  // planar chroma scales
  localparam logic [1:0] CS_H2V2 = 2'd0;
  localparam logic [1:0] CS_H2V1 = 2'd1;
  localparam logic [1:0] CS_H1V2 = 2'd2;
  localparam logic [1:0] CS_H1V1 = 2'd3;

  // plane tags
  localparam logic [1:0] TAG_LUMA    = 2'd0;
  localparam logic [1:0] TAG_CHROMA1 = 2'd1;
  localparam logic [1:0] TAG_CHROMA2 = 2'd2;
  localparam logic [1:0] TAG_PACKED  = 2'd3;

  // coefficient in thousandths scaled to the fixed-point grid, rounded half up
  function automatic logic [SUM_W-1:0] coef(input longint milli);
    return SUM_W'(((milli <<< COEF_FRAC_BITS) + 64'sd500) / 1000);
  endfunction

  localparam logic [SUM_W-1:0] C_YR = coef(257);
  localparam logic [SUM_W-1:0] C_YG = coef(504);
  localparam logic [SUM_W-1:0] C_YB = coef(98);
  localparam logic [SUM_W-1:0] C_UR = coef(148);
  localparam logic [SUM_W-1:0] C_UG = coef(291);
  localparam logic [SUM_W-1:0] C_UB = coef(439);
  localparam logic [SUM_W-1:0] C_VR = coef(439);
  localparam logic [SUM_W-1:0] C_VG = coef(368);
  localparam logic [SUM_W-1:0] C_VB = coef(71);
  localparam logic [SUM_W-1:0] OFF_16  = SUM_W'(64'd16 << COEF_FRAC_BITS);
  localparam logic [SUM_W-1:0] OFF_128 = SUM_W'(64'd128 << COEF_FRAC_BITS);

  // per-pixel decisions taken at input time
  typedef struct packed {
    logic packed_mode;
    logic uyvy;
    logic odd;
    logic keep;
    logic eof;
    logic swap;
  } ctrl_t;

  // load of the output serializer, entry 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0][1:0] tags;
    logic [2:0]      cnt;
    logic            eof;
  } ser_load_t;

endpackage

### rtl/core/rgb_to_ycbcr_subsample_pack.sv
// channel   dir  payload                                   handshake
// s_axis    in   tdata: red, green, blue                   tvalid/tready
// m_axis    out  tdata: sample, tuser: plane_tag/frame_end tvalid/tready, tlast
// cfg       in   index 0..4, 13-bit data                   cfg_we_i, no wait
//
// an accepted pixel sits in the input register, is converted and formatted, and
// loads the output serializer, which sends one byte per cycle while m_axis_tready is high
// pixels then follow at the pace of the serializer: a planar pixel sends three bytes with
// chroma or one luma byte, a packed pair four; a load may come as the last byte leaves
// packed even pixels only update the held pair and leave no bytes
// reset clears counters and held pair and sets the config registers to their defaults
// depends on rysp_pkg, rysp_pos, rysp_csc, rysp_ser
module rgb_to_ycbcr_subsample_pack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // sample [7:0]
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser    // plane_tag [1:0], frame_end [2]
);

  logic [rysp_pkg::DIM_W-1:0] width_q, height_q;
  logic [1:0] format_q, scale_q;
  logic       swap_q;

  logic            s1_valid_q;
  logic [23:0]     s1_rgb_q;
  rysp_pkg::ctrl_t s1_ctrl_q, pos_ctrl;

  logic [7:0] held_y_q, held_u_q, held_v_q;
  logic [7:0] cy, cu, cv, first, second;
  logic       produce, s1_fire, ser_free, load, s_accept;
  rysp_pkg::ser_load_t ld;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign produce       = !(s1_ctrl_q.packed_mode && !s1_ctrl_q.odd);
  assign s1_fire       = s1_valid_q && (!produce || ser_free);
  assign load          = s1_fire && produce;
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      format_q <= rysp_pkg::FMT_PLANAR;
      scale_q  <= rysp_pkg::CS_H1V1;
      swap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rysp_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i;
        rysp_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i;
        rysp_pkg::REG_OUTPUT_FORMAT: format_q <= cfg_wdata_i[1:0];
        rysp_pkg::REG_CHROMA_SCALE:  scale_q  <= cfg_wdata_i[1:0];
        rysp_pkg::REG_UV_SWAP:       swap_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  rysp_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .width_i  (width_q),
    .height_i (height_q),
    .format_i (format_q),
    .scale_i  (scale_q),
    .swap_i   (swap_q),
    .ctrl_o   (pos_ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_rgb_q  <= s_axis_tdata;
      s1_ctrl_q <= pos_ctrl;
    end
  end

  rysp_csc u_csc (
    .red_i   (s1_rgb_q[7:0]),
    .green_i (s1_rgb_q[15:8]),
    .blue_i  (s1_rgb_q[23:16]),
    .y_o     (cy),
    .u_o     (cu),
    .v_o     (cv)
  );

  assign first  = s1_ctrl_q.swap ? cv : cu;
  assign second = s1_ctrl_q.swap ? cu : cv;

  // even pixel of a packed pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_y_q <= '0;
      held_u_q <= '0;
      held_v_q <= '0;
    end else if (s1_fire && !produce) begin
      held_y_q <= cy;
      held_u_q <= first;
      held_v_q <= second;
    end
  end

  always_comb begin
    ld.eof = s1_ctrl_q.eof;
    if (s1_ctrl_q.packed_mode) begin
      ld.cnt  = 3'd4;
      ld.tags = {4{rysp_pkg::TAG_PACKED}};
      if (s1_ctrl_q.uyvy) begin
        ld.bytes = {cy, held_v_q, held_y_q, held_u_q};
      end else begin
        ld.bytes = {held_v_q, cy, held_u_q, held_y_q};
      end
    end else begin
      ld.cnt   = s1_ctrl_q.keep ? 3'd3 : 3'd1;
      ld.bytes = {8'd0, second, first, cy};
      ld.tags  = {rysp_pkg::TAG_LUMA, rysp_pkg::TAG_CHROMA2,
                  rysp_pkg::TAG_CHROMA1, rysp_pkg::TAG_LUMA};
    end
  end

  rysp_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .load_data_i   (ld),
    .free_o        (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### rtl/core/rysp_pos.sv
// column and row tracker with per-pixel mode decisions
// depends on rysp_pkg and rgb_to_ycbcr_subsample_pack_assert.svh
`include "rgb_to_ycbcr_subsample_pack_assert.svh"

module rysp_pos (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [rysp_pkg::DIM_W-1:0]  width_i,
  input  logic [rysp_pkg::DIM_W-1:0]  height_i,
  input  logic [1:0]                  format_i,
  input  logic [1:0]                  scale_i,
  input  logic                        swap_i,
  output rysp_pkg::ctrl_t             ctrl_o
);

  logic [rysp_pkg::CNT_W-1:0] col_q, col_d;
  logic [rysp_pkg::CNT_W-1:0] row_q, row_d;
  logic [rysp_pkg::DIM_W-1:0] w, h, cw, ch;
  logic end_of_row, end_of_frame, xm, ym;

  function automatic logic [rysp_pkg::DIM_W-1:0] eff_dim(
    input logic [rysp_pkg::DIM_W-1:0] d
  );
    logic [rysp_pkg::DIM_W-1:0] r;
    if (d == '0) begin
      r = rysp_pkg::DIM_W'(1);
    end else if (d > rysp_pkg::MAX_DIM) begin
      r = rysp_pkg::MAX_DIM;
    end else begin
      r = d;
    end
    return r;
  endfunction

  always_comb begin
    w = eff_dim(width_i);
    h = eff_dim(height_i);
    end_of_row   = ({1'b0, col_q} + 13'd1) >= w;
    end_of_frame = end_of_row && (({1'b0, row_q} + 13'd1) >= h);
    xm = (scale_i == rysp_pkg::CS_H2V2) || (scale_i == rysp_pkg::CS_H2V1);
    ym = (scale_i == rysp_pkg::CS_H2V2) || (scale_i == rysp_pkg::CS_H1V2);
    cw = xm ? {1'b0, w[rysp_pkg::DIM_W-1:1]} : w;
    ch = ym ? {1'b0, h[rysp_pkg::DIM_W-1:1]} : h;

    ctrl_o.packed_mode = (format_i == rysp_pkg::FMT_YUYV) ||
                         (format_i == rysp_pkg::FMT_UYVY);
    ctrl_o.uyvy = (format_i == rysp_pkg::FMT_UYVY);
    ctrl_o.odd  = col_q[0];
    ctrl_o.keep = !(row_q[0] && ym) && !(col_q[0] && xm) &&
                  ({2'b00, row_q[rysp_pkg::CNT_W-1:1]} < ch) &&
                  ({2'b00, col_q[rysp_pkg::CNT_W-1:1]} < cw);
    ctrl_o.eof  = end_of_frame;
    ctrl_o.swap = swap_i;

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (end_of_row) begin
        col_d = '0;
        row_d = end_of_frame ? '0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `RYSP_ASSERT_NEXT(a_frame_wrap, accept_i && end_of_frame, (col_q == '0) && (row_q == '0), "position did not wrap at frame end")
  `RYSP_ASSERT_NEXT(a_col_step, accept_i && !end_of_row, col_q == $past(col_q) + 12'd1, "column did not advance")

endmodule

### rtl/core/rysp_csc.sv
// fixed-point rgb to studio-range ycbcr conversion with clamping
// depends on rysp_pkg
module rysp_csc (
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic [7:0] y_o,
  output logic [7:0] u_o,
  output logic [7:0] v_o
);

  localparam int SW = rysp_pkg::SUM_W;
  localparam int FB = rysp_pkg::COEF_FRAC_BITS;

  logic [SW-1:0] r, g, b, sy, su, sv;

  // negative gives 0, integer part above 255 gives 255
  function automatic logic [7:0] to_byte(input logic [SW-1:0] s);
    logic [SW-2-FB:0] ip;
    logic [7:0] res;
    ip = s[SW-2:FB];
    if (s[SW-1]) begin
      res = 8'd0;
    end else if (ip > 9'd255) begin
      res = 8'd255;
    end else begin
      res = ip[7:0];
    end
    return res;
  endfunction

  always_comb begin
    r = SW'(red_i);
    g = SW'(green_i);
    b = SW'(blue_i);
    sy = rysp_pkg::C_YR * r + rysp_pkg::C_YG * g + rysp_pkg::C_YB * b + rysp_pkg::OFF_16;
    su = rysp_pkg::OFF_128 - rysp_pkg::C_UR * r - rysp_pkg::C_UG * g + rysp_pkg::C_UB * b;
    sv = rysp_pkg::OFF_128 + rysp_pkg::C_VR * r - rysp_pkg::C_VG * g - rysp_pkg::C_VB * b;
    y_o = to_byte(sy);
    u_o = to_byte(su);
    v_o = to_byte(sv);
  end

endmodule

### rtl/core/rysp_ser.sv
// output serializer: holds up to four bytes of one load, sends one per cycle while m_axis_tready is high
// depends on rysp_pkg and rgb_to_ycbcr_subsample_pack_assert.svh
`include "rgb_to_ycbcr_subsample_pack_assert.svh"

module rysp_ser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  rysp_pkg::ser_load_t  load_data_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // sample
  output logic                 m_axis_tlast,
  output logic [2:0]           m_axis_tuser   // plane_tag [1:0], frame_end [2]
);

  logic [2:0]      cnt_q;
  logic [3:0][7:0] data_q;
  logic [3:0][1:0] tag_q;
  logic            eof_q;
  logic            take;

  assign take          = (cnt_q != 3'd0) && m_axis_tready;
  assign free_o        = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready);
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = data_q[0];
  assign m_axis_tlast  = (cnt_q == 3'd1);
  assign m_axis_tuser  = {eof_q, tag_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= load_data_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // payload, shifted down as items leave
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i.bytes;
      tag_q  <= load_data_i.tags;
      eof_q  <= load_data_i.eof;
    end else if (take) begin
      data_q <= {8'd0, data_q[3:1]};
      tag_q  <= {2'd0, tag_q[3:1]};
    end
  end

  `RYSP_ASSERT_NOW(a_load_when_free, load_i, free_o, "serializer loaded while still busy")
  `RYSP_ASSERT_NEXT(a_drain, take && !load_i && (cnt_q > 3'd1), cnt_q == $past(cnt_q) - 3'd1, "serializer count did not drain")
  `RYSP_ASSERT_NOW(a_cnt_range, load_i, (load_data_i.cnt == 3'd1) || (load_data_i.cnt == 3'd3) || (load_data_i.cnt == 3'd4), "bad item count on load")

endmodule
